FILE: hw/rtl/scd_pkg.sv
// Shared types and constants for the stall collision detector.
// Used by scd_front, scd_back and the top level; depends on nothing.
`timescale 1ns / 1ps

package scd_pkg;

  localparam int ERR_W      = 24;
  localparam int MAG_W      = 23;
  localparam int TIME_W     = 32;
  localparam int WLEN_W     = 4;
  localparam int HITS_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 23;
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 64;

  localparam int MAX_WINDOW_DEFAULT = 8;
  localparam int QUEUE_DEPTH        = 2;

  localparam logic [MAG_W-1:0]  MAG_MAX         = 23'h7F_FFFF;
  localparam logic [MAG_W-1:0]  THRESHOLD_RESET = 23'd150;
  localparam logic [WLEN_W-1:0] WINDOW_RESET    = 4'd5;
  localparam logic [HITS_W-1:0] HITS_RESET      = 8'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD = 2'd0,
    REG_WINDOW    = 2'd1,
    REG_HITS      = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [MAG_W-1:0]  threshold;
    logic [WLEN_W-1:0] window_length;
    logic [HITS_W-1:0] hits_to_react;
  } cfg_t;

  // One classified poll, passed from the front end to the back end.
  typedef struct packed {
    logic [MAG_W-1:0]  magnitude;
    logic              shaft_blocked;
    logic [TIME_W-1:0] sample_time_ms;
  } queue_word_t;

  typedef struct packed {
    logic              react;
    logic [TIME_W-1:0] detect_latency_ms;
    logic              detect_valid;
    logic              collision;
    logic [MAG_W-1:0]  average_error;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SUM,
    ST_DIVIDE,
    ST_FINISH
  } back_state_t;

endpackage

FILE: hw/rtl/scd_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; holds the error window of the detector.
`timescale 1ns / 1ps

module scd_ram #(
  parameter int WIDTH = 23,
  parameter int DEPTH = 8
) (
  input  logic                                    clk,
  input  logic                                    wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                        wr_data,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                        rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: hw/rtl/scd_front.sv
// Front end: accepts polls, folds the angle error to a saturated magnitude
// and holds the result in a short queue for the back end. Uses scd_pkg.
`timescale 1ns / 1ps

module scd_front import scd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_TDATA_W-1:0] s_axis_tdata,
  output logic                  q_valid,
  input  logic                  q_ready,
  output queue_word_t           q_word
);

  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  queue_word_t       entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  logic [ERR_W-1:0] angle_error;
  logic [ERR_W-1:0] abs_error;
  queue_word_t      in_word;
  logic             push;
  logic             pop;

  assign angle_error = s_axis_tdata[ERR_W-1:0];
  // The most negative error has no positive twin and lands with bit 23 set.
  assign abs_error   = angle_error[ERR_W-1] ? (~angle_error + 1'b1) : angle_error;

  always_comb begin
    in_word.magnitude      = abs_error[ERR_W-1] ? MAG_MAX : abs_error[MAG_W-1:0];
    in_word.shaft_blocked  = s_axis_tdata[ERR_W];
    in_word.sample_time_ms = s_axis_tdata[ERR_W+TIME_W:ERR_W+1];
  end

  assign s_axis_tready = (count != QCNT_W'(QUEUE_DEPTH));
  assign push          = s_axis_tvalid && s_axis_tready;
  assign q_valid       = (count != '0);
  assign pop           = q_valid && q_ready;
  assign q_word        = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= in_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: hw/rtl/scd_back.sv
// Back end: keeps the error window in RAM, sums it entry by entry, divides
// with a bit-serial divider and runs the collision bookkeeping.
// Uses scd_pkg and scd_ram.
`timescale 1ns / 1ps

module scd_back import scd_pkg::*; #(
  parameter int MAX_WINDOW = MAX_WINDOW_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        q_valid,
  output logic        q_ready,
  input  queue_word_t q_word,
  output logic        res_valid,
  input  logic        res_ready,
  output result_t     res
);

  localparam int ADDR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int FILL_W = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W  = MAG_W + FILL_W;
  localparam int DCNT_W = $clog2(SUM_W + 1);
  localparam int CMP_W  = (FILL_W > WLEN_W) ? FILL_W : WLEN_W;

  back_state_t state, state_next;

  logic [ADDR_W-1:0] head;
  logic [FILL_W-1:0] fill;
  logic [ADDR_W-1:0] walk_idx;
  logic [FILL_W-1:0] rd_cnt;
  logic              rd_pend;
  logic [SUM_W-1:0]  sum;
  logic [FILL_W-1:0] rem;
  logic [SUM_W-1:0]  quo;
  logic [DCNT_W-1:0] div_cnt;
  queue_word_t       cur;
  logic [HITS_W-1:0] hit_run;
  logic              in_coll;
  logic [TIME_W-1:0] last_free;
  logic [TIME_W-1:0] lat;
  logic              lat_valid;

  logic [MAG_W-1:0]  rd_data;
  logic              ram_we;
  logic [CMP_W-1:0]  wl_ext;
  logic [FILL_W-1:0] len;
  logic [FILL_W:0]   fill_inc;
  logic [FILL_W-1:0] fill_new;
  logic [ADDR_W-1:0] head_new;
  logic [ADDR_W-1:0] walk_prev;
  logic [FILL_W:0]   rem_sh;
  logic              rem_ge;
  logic [FILL_W:0]   rem_diff;
  logic [MAG_W-1:0]  avg;
  logic              coll;
  logic [HITS_W-1:0] hit_new;
  logic [HITS_W-1:0] need;
  logic              react;
  logic              new_start;
  logic [TIME_W-1:0] lat_new;
  logic              res_free;
  logic              sum_done;
  logic              finish_go;

  scd_ram #(
    .WIDTH (MAG_W),
    .DEPTH (MAX_WINDOW)
  ) u_ring (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (head),
    .wr_data (q_word.magnitude),
    .rd_addr (walk_prev),
    .rd_data (rd_data)
  );

  // Window geometry for this poll.
  always_comb begin
    wl_ext = CMP_W'(cfg.window_length);
    if (cfg.window_length == '0) begin
      len = FILL_W'(1);
    end else if (wl_ext > CMP_W'(MAX_WINDOW)) begin
      len = FILL_W'(MAX_WINDOW);
    end else begin
      len = wl_ext[FILL_W-1:0];
    end
    fill_inc  = {1'b0, fill} + 1'b1;
    fill_new  = (fill_inc > {1'b0, len}) ? len : fill_inc[FILL_W-1:0];
    head_new  = (head == ADDR_W'(MAX_WINDOW - 1)) ? '0 : head + 1'b1;
    walk_prev = (walk_idx == '0) ? ADDR_W'(MAX_WINDOW - 1) : walk_idx - 1'b1;
  end

  // One quotient bit per cycle.
  always_comb begin
    rem_sh   = {rem, quo[SUM_W-1]};
    rem_ge   = (rem_sh >= {1'b0, fill});
    rem_diff = rem_sh - {1'b0, fill};
  end

  // Collision bookkeeping for the poll in hand.
  always_comb begin
    avg       = (|quo[SUM_W-1:MAG_W]) ? MAG_MAX : quo[MAG_W-1:0];
    coll      = (avg > cfg.threshold) || cur.shaft_blocked;
    if (!coll) begin
      hit_new = '0;
    end else if (hit_run == '1) begin
      hit_new = hit_run;
    end else begin
      hit_new = hit_run + 1'b1;
    end
    need      = (cfg.hits_to_react == '0) ? HITS_W'(1) : cfg.hits_to_react;
    react     = (hit_new >= need);
    new_start = coll && !in_coll;
    lat_new   = new_start ? (cur.sample_time_ms - last_free) : lat;
  end

  assign res_free  = !res_valid || res_ready;
  assign sum_done  = (rd_cnt == fill) && !rd_pend;
  assign finish_go = (state == ST_FINISH) && res_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_ready    = 1'b0;
    ram_we     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          ram_we     = 1'b1;
          state_next = ST_SUM;
        end
      end
      ST_SUM: begin
        if (sum_done) begin
          state_next = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (div_cnt == DCNT_W'(1)) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (res_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Working registers of the sum and the divider.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (q_valid) begin
            cur      <= q_word;
            walk_idx <= head_new;
            rd_cnt   <= '0;
            rd_pend  <= 1'b0;
            sum      <= '0;
          end
        end
        ST_SUM: begin
          // The RAM answers in the cycle after the address, so reads and adds overlap.
          if (rd_cnt != fill) begin
            walk_idx <= walk_prev;
            rd_cnt   <= rd_cnt + 1'b1;
            rd_pend  <= 1'b1;
          end else begin
            rd_pend  <= 1'b0;
          end
          if (rd_pend) begin
            sum <= sum + SUM_W'(rd_data);
          end
          if (sum_done) begin
            quo     <= sum;
            rem     <= '0;
            div_cnt <= DCNT_W'(SUM_W);
          end
        end
        ST_DIVIDE: begin
          rem     <= rem_ge ? rem_diff[FILL_W-1:0] : rem_sh[FILL_W-1:0];
          quo     <= {quo[SUM_W-2:0], rem_ge};
          div_cnt <= div_cnt - 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Window position, hit run, latency and the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      fill      <= '0;
      hit_run   <= '0;
      in_coll   <= 1'b0;
      last_free <= '0;
      lat       <= '0;
      lat_valid <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (ram_we) begin
        head <= head_new;
        fill <= fill_new;
      end
      if (finish_go) begin
        res_valid             <= 1'b1;
        res.average_error     <= avg;
        res.collision         <= coll;
        res.detect_valid      <= lat_valid || new_start;
        res.detect_latency_ms <= (lat_valid || new_start) ? lat_new : '0;
        res.react             <= react;
        if (react) begin
          head      <= '0;
          fill      <= '0;
          hit_run   <= '0;
          in_coll   <= 1'b0;
          lat       <= '0;
          lat_valid <= 1'b0;
          last_free <= cur.sample_time_ms;
        end else begin
          hit_run   <= hit_new;
          lat       <= lat_new;
          lat_valid <= lat_valid || new_start;
          in_coll   <= coll;
          if (!coll) begin
            last_free <= cur.sample_time_ms;
          end
        end
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(MAX_WINDOW))
    else $error("window fill count beyond the window size");

  a_react_clears: assert property (@(posedge clk) disable iff (rst)
    (finish_go && react) |=> (fill == '0 && hit_run == '0 && !lat_valid && !in_coll))
    else $error("react did not clear the window and the counters");

  a_latency_idle_zero: assert property (@(posedge clk) disable iff (rst)
    !lat_valid |-> (lat == '0))
    else $error("latched latency is nonzero while not valid");

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIVIDE) |-> (rem < fill))
    else $error("divider remainder not below the fill count");

endmodule

FILE: hw/rtl/stall_collision_detector_top.sv
// Top level of the stall collision detector: configuration registers, the
// front end with its queue and the back end. Uses scd_pkg, scd_front, scd_back.
// Each accepted word passes the window walk over the single RAM read port and
// the one-bit-per-cycle divider, which yields SUM_W = 23 + clog2(MAX_WINDOW + 1)
// quotient bits, before its result word; the back end takes no new word until
// its last result is in the output register, while the queue holds two polls.
// Reset is synchronous and active high; it restores the register defaults and
// empties the window and the queue at once, with no clearing pass.
`timescale 1ns / 1ps

module stall_collision_detector_top import scd_pkg::*; #(
  parameter int MAX_WINDOW = MAX_WINDOW_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // angle_error[23:0], shaft_blocked[24], sample_time_ms[56:25], zeros above
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // average_error[22:0], collision[23], detect_valid[24],
  // detect_latency_ms[56:25], react[57], zeros above
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t        cfg;
  logic        q_valid;
  logic        q_ready;
  queue_word_t q_word;
  result_t     res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold     <= THRESHOLD_RESET;
      cfg.window_length <= WINDOW_RESET;
      cfg.hits_to_react <= HITS_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_THRESHOLD: cfg.threshold     <= cfg_data[MAG_W-1:0];
        REG_WINDOW:    cfg.window_length <= cfg_data[WLEN_W-1:0];
        REG_HITS:      cfg.hits_to_react <= cfg_data[HITS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  scd_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .q_valid       (q_valid),
    .q_ready       (q_ready),
    .q_word        (q_word)
  );

  scd_back #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_word    (q_word),
    .res_valid (m_axis_tvalid),
    .res_ready (m_axis_tready),
    .res       (res)
  );

  assign m_axis_tdata = {(OUT_TDATA_W - $bits(result_t))'(0), res};

endmodule
